>>> sv/efba_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// efba_pkg
// Shared types and constants for the exact-fit bump allocator.
// ---------------------------------------------------------------------------
package efba_pkg;

    // Field widths of the request and result transfers.
    localparam int SIZE_W   = 22;
    localparam int SEGIDX_W = 4;
    localparam int OFF_W    = 24;
    localparam int SEG_W    = 25;
    localparam int STATUS_W = 2;

    // Offsets are limited to this many bits; larger segments are clipped.
    localparam int OFFSET_BITS = 24;

    localparam logic [SEG_W-1:0] SEG_CAP        = SEG_W'(2 ** OFFSET_BITS);
    localparam logic [SEG_W-1:0] SEG_SIZE_RESET = SEG_W'(1048576);

    // Request kinds.
    localparam logic REQ_ALLOC  = 1'b0;
    localparam logic REQ_RETURN = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_SEG   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    // One free table entry.
    typedef struct packed {
        logic [SEGIDX_W-1:0] seg;
        logic [OFF_W-1:0]    off;
        logic [SIZE_W-1:0]   size;
    } free_entry_t;

    // One result as it leaves the controller.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SEGIDX_W-1:0] seg;
        logic [OFF_W-1:0]    off;
        logic                reused;
    } result_t;

endpackage
`default_nettype wire

>>> sv/efba_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// efba_if
// Valid/ready channels for allocator requests and results.
// ---------------------------------------------------------------------------
interface efba_req_if import efba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [SIZE_W-1:0]   block_size;
    logic [SEGIDX_W-1:0] ret_segment;
    logic [OFF_W-1:0]    ret_offset;

    modport source (output valid, output req_type, output block_size,
                    output ret_segment, output ret_offset, input ready);
    modport sink   (input valid, input req_type, input block_size,
                    input ret_segment, input ret_offset, output ready);
endinterface

interface efba_rsp_if import efba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SEGIDX_W-1:0] out_segment;
    logic [OFF_W-1:0]    out_offset;
    logic                reused;

    modport source (output valid, output status, output out_segment,
                    output out_offset, output reused, input ready);
    modport sink   (input valid, input status, input out_segment,
                    input out_offset, input reused, output ready);
endinterface
`default_nettype wire

>>> sv/efba_free_mem.sv
`default_nettype none
// ---------------------------------------------------------------------------
// efba_free_mem
// Free table storage: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module efba_free_mem
    import efba_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  wire logic        clk,
    input  wire logic        we,
    input  wire logic [AW-1:0] waddr,
    input  wire free_entry_t wdata,
    input  wire logic [AW-1:0] raddr,
    output free_entry_t      rdata
);

    free_entry_t mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> sv/efba_out_stage.sv
`default_nettype none
// ---------------------------------------------------------------------------
// efba_out_stage
// Output register that holds one finished result until it is transferred.
// ---------------------------------------------------------------------------
module efba_out_stage
    import efba_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   res_valid,
    output logic        res_ready,
    input  wire result_t res,
    efba_rsp_if.source  rsp
);

    logic    valid_reg;
    result_t data_reg;

    // The register is free when empty or being drained in this cycle.
    assign res_ready = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign rsp.valid       = valid_reg;
    assign rsp.status      = data_reg.status;
    assign rsp.out_segment = data_reg.seg;
    assign rsp.out_offset  = data_reg.off;
    assign rsp.reused      = data_reg.reused;

endmodule
`default_nettype wire

>>> sv/efba_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// efba_ctrl
// Request sequencer: size check, free table scan and close-up, bump pointer.
// ---------------------------------------------------------------------------
module efba_ctrl
    import efba_pkg::*;
#(
    parameter int FREE_ENTRIES = 64,
    parameter int MAX_SEGMENTS = 16,
    parameter int FC_W         = 7,
    parameter int FA_W         = 6
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [SEG_W-1:0] cfg_wdata,
    efba_req_if.sink              req,
    output logic                  mem_we,
    output logic [FA_W-1:0]       mem_waddr,
    output free_entry_t           mem_wdata,
    output logic [FA_W-1:0]       mem_raddr,
    input  wire free_entry_t      mem_rdata,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output result_t               res
);

    localparam int SU_W = $clog2(MAX_SEGMENTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic                typ_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic [SEGIDX_W-1:0] rseg_reg;
    logic [OFF_W-1:0]    roff_reg;
    logic [SEG_W-1:0]    seg_size_reg;
    logic [SEG_W-1:0]    bump_reg, bump_next;
    logic [SU_W-1:0]     su_reg, su_next;
    logic [FC_W-1:0]     cnt_reg, cnt_next;
    logic [FC_W-1:0]     idx_reg, idx_next;
    result_t             res_reg, res_next;

    logic [SEG_W-1:0]    seg_eff;
    logic [SEG_W-3:0]    quarter;
    logic                bad_size;
    logic [SEG_W:0]      bump_sum;
    logic                overrun;
    logic                seg_full;
    logic [SU_W+3:0]     cur_seg_ext;
    logic [SU_W+3:0]     new_seg_ext;
    result_t             b_res;
    logic [SEG_W-1:0]    b_bump;
    logic [SU_W-1:0]     b_su;
    logic                hit;
    logic [FC_W:0]       idx_p1;
    logic [FC_W:0]       idx_p2;

    // Size check: reject a zero size or one at or above a quarter of the clipped segment size.
    always_comb
    begin
        seg_eff  = (seg_size_reg > SEG_CAP) ? SEG_CAP : seg_size_reg;
        quarter  = seg_eff[SEG_W-1:2];
        bad_size = (size_reg == '0) || ({1'b0, size_reg} >= quarter);
    end

    // Bump allocation outcome, used when no free entry fits.
    always_comb
    begin
        bump_sum    = {1'b0, bump_reg} + (SEG_W + 1)'(size_reg);
        overrun     = bump_sum > {1'b0, seg_eff};
        seg_full    = su_reg >= SU_W'(MAX_SEGMENTS);
        cur_seg_ext = {4'b0, su_reg} - (SU_W + 4)'(1);
        new_seg_ext = {4'b0, su_reg};
        b_res       = '0;
        b_bump      = bump_reg;
        b_su        = su_reg;
        if (!overrun)
        begin
            b_res.status = ST_OK;
            b_res.seg    = cur_seg_ext[SEGIDX_W-1:0];
            b_res.off    = bump_reg[OFF_W-1:0];
            b_bump       = bump_sum[SEG_W-1:0];
        end
        else if (seg_full)
        begin
            b_res.status = ST_NO_SEG;
        end
        else
        begin
            b_res.status = ST_OK;
            b_res.seg    = new_seg_ext[SEGIDX_W-1:0];
            b_bump       = SEG_W'(size_reg);
            b_su         = su_reg + SU_W'(1);
        end
    end

    // Sequencer.
    always_comb
    begin
        hit        = mem_rdata.size == size_reg;
        idx_p1     = {1'b0, idx_reg} + (FC_W + 1)'(1);
        idx_p2     = {1'b0, idx_reg} + (FC_W + 1)'(2);
        state_next = state_reg;
        bump_next  = bump_reg;
        su_next    = su_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = cnt_reg[FA_W-1:0];
        mem_wdata  = '{seg: rseg_reg, off: roff_reg, size: size_reg};
        mem_raddr  = '0;
        req.ready  = 1'b0;
        res_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_OUT;
                res_next   = '0;
                if (bad_size)
                begin
                    res_next.status = ST_BAD_SIZE;
                end
                else if (typ_reg == REQ_RETURN)
                begin
                    if (cnt_reg >= FC_W'(FREE_ENTRIES))
                    begin
                        res_next.status = ST_FULL;
                    end
                    else
                    begin
                        mem_we   = 1'b1;
                        cnt_next = cnt_reg + FC_W'(1);
                    end
                end
                else if (cnt_reg == '0)
                begin
                    res_next  = b_res;
                    bump_next = b_bump;
                    su_next   = b_su;
                end
                else
                begin
                    mem_raddr  = '0;
                    idx_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Read data belongs to entry idx_reg.
                if (hit)
                begin
                    res_next = '{status: ST_OK, seg: mem_rdata.seg,
                                 off: mem_rdata.off, reused: 1'b1};
                    if (idx_p1 < {1'b0, cnt_reg})
                    begin
                        mem_raddr  = idx_p1[FA_W-1:0];
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg - FC_W'(1);
                        state_next = S_OUT;
                    end
                end
                else if (idx_p1 < {1'b0, cnt_reg})
                begin
                    mem_raddr = idx_p1[FA_W-1:0];
                    idx_next  = idx_p1[FC_W-1:0];
                end
                else
                begin
                    res_next   = b_res;
                    bump_next  = b_bump;
                    su_next    = b_su;
                    state_next = S_OUT;
                end
            end
            S_SHIFT:
            begin
                // Move entry idx_reg+1 down into idx_reg.
                mem_we    = 1'b1;
                mem_waddr = idx_reg[FA_W-1:0];
                mem_wdata = mem_rdata;
                if (idx_p2 < {1'b0, cnt_reg})
                begin
                    mem_raddr = idx_p2[FA_W-1:0];
                    idx_next  = idx_p1[FC_W-1:0];
                end
                else
                begin
                    cnt_next   = cnt_reg - FC_W'(1);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res = res_reg;

    // Control state and allocator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            seg_size_reg <= SEG_SIZE_RESET;
            bump_reg     <= '0;
            su_reg       <= SU_W'(1);
            cnt_reg      <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;
            bump_reg  <= bump_next;
            su_reg    <= su_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            if (cfg_we)
            begin
                seg_size_reg <= cfg_wdata;
            end
        end
    end

    // Request fields and result payload.
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (req.valid && req.ready)
        begin
            typ_reg  <= req.req_type;
            size_reg <= req.block_size;
            rseg_reg <= req.ret_segment;
            roff_reg <= req.ret_offset;
        end
    end

endmodule
`default_nettype wire

>>> sv/exact_fit_bump_allocator_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// exact_fit_bump_allocator_top
// Exact-fit allocator with a free table in memory and a segment bump pointer.
// ---------------------------------------------------------------------------
//  Channel  Dir  Handshake        Payload
//  req      in   valid/ready      req_type, block_size, ret_segment, ret_offset
//  rsp      out  valid/ready      status, out_segment, out_offset, reused
//  cfg      in   cfg_we           cfg_wdata (segment_size)
//
//  One item is handled at a time. A return or a request with a bad size goes from
//  the evaluate state straight to the output state; an allocation reads the free
//  table one entry per cycle and closes up the table behind a hit one entry per
//  cycle, as the single memory read port allows.
//  Reset leaves an empty free table and segment zero open at offset zero.
//  A new request is taken while the previous result waits in the output register.
// ---------------------------------------------------------------------------
module exact_fit_bump_allocator_top
    import efba_pkg::*;
#(
    parameter int FREE_ENTRIES = 64,
    parameter int MAX_SEGMENTS = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [SEG_W-1:0] cfg_wdata,
    efba_req_if.sink              req,
    efba_rsp_if.source            rsp
);

    localparam int FC_W = $clog2(FREE_ENTRIES + 1);
    localparam int FA_W = (FREE_ENTRIES > 1) ? $clog2(FREE_ENTRIES) : 1;

    logic            mem_we;
    logic [FA_W-1:0] mem_waddr;
    logic [FA_W-1:0] mem_raddr;
    free_entry_t     mem_wdata;
    free_entry_t     mem_rdata;
    logic            res_valid;
    logic            res_ready;
    result_t         res;

    // Request sequencer.
    efba_ctrl #(
        .FREE_ENTRIES (FREE_ENTRIES),
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .FC_W         (FC_W),
        .FA_W         (FA_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Free table.
    efba_free_mem #(
        .DEPTH (FREE_ENTRIES),
        .AW    (FA_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Result register.
    efba_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire
